// ===== rtl/rainbow_wave_pixel_generator_unit_defines.svh =====
// Assertion macros shared by the rainbow wave pixel generator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef RAINBOW_WAVE_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define RAINBOW_WAVE_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RWPG_ASSERT_NOW(name, cks, rstn, ante, cons) \
	name: assert property (@(posedge cks) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rwpg: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define RWPG_ASSERT_NEXT(name, cks, rstn, ante, cons) \
	name: assert property (@(posedge cks) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rwpg: next-cycle check failed");

`endif

// ===== rtl/rwpg_pkg.sv =====
// Shared types and constants for the rainbow wave pixel generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package rwpg_pkg;

	localparam int LEDS_DEF     = 12;
	localparam int IDX_W        = 6;
	localparam int HUE_W        = 9;
	localparam int CH_W         = 8;
	localparam int PCT_W        = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;
	// cycles for the brightness/saturation derived levels to settle
	localparam int SETUP_CYCLES = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 2'd0,
		REG_BRIGHTNESS = 2'd1,
		REG_HUE_STEP   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} rwpg_state_t;

	typedef struct packed {
		logic             start;
		logic             issue;
		logic             last;
		logic [IDX_W-1:0] idx;
	} rwpg_cmd_t;

	typedef struct packed {
		logic adv;
	} rwpg_status_t;

endpackage

`default_nettype wire

// ===== rtl/rainbow_wave_pixel_generator_unit.sv =====
// Rainbow wave pixel generator: an animated hue wheel across an LED strip.
// Input channel in_valid/in_ready carries frame_tick; each tick of 1 starts one frame,
// a tick of 0 is transferred and dropped without output.
// Output channel out_valid/out_ready carries one pixel per transfer: led_index,
// red, green, blue and last_pixel, which marks the final LED of the frame.
// Configuration: cfg_write with cfg_index 0 saturation, 1 brightness, 2 hue_step;
// the user must write them only while no frame is in flight; the block does not enforce this.
// After the tick transfer the level setup runs, then the first pixel passes the pixel pipeline.
// Throughput: one pixel per cycle while out_ready is held high; the input takes a new tick
// only once the level setup and the pixel issue loop of the previous frame are done.
// A stalled receiver freezes the whole five-stage pixel pipeline; nothing is dropped.
// Reset: saturation 100, brightness 20, hue_step 2, base hue 0, pipeline empty.
// Depends on rwpg_pkg, rwpg_ctrl and rwpg_datapath.
`default_nettype none

module rainbow_wave_pixel_generator_unit import rwpg_pkg::*; #(
	parameter int LEDS = LEDS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  frame_tick,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [IDX_W-1:0]           led_index,
	output logic [CH_W-1:0]            red,
	output logic [CH_W-1:0]            green,
	output logic [CH_W-1:0]            blue,
	output logic                       last_pixel
);

	rwpg_cmd_t    cmd;
	rwpg_status_t status;

	rwpg_ctrl #(
		.LEDS(LEDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_tick(frame_tick),
		.status    (status),
		.cmd       (cmd)
	);

	rwpg_datapath #(
		.LEDS(LEDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led_index (led_index),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last_pixel(last_pixel)
	);

endmodule

`default_nettype wire

// ===== rtl/rwpg_ctrl.sv =====
// Frame sequencer for the rainbow wave pixel generator.
// Depends on rwpg_pkg and the assertion macros header.
`default_nettype none
`include "rainbow_wave_pixel_generator_unit_defines.svh"

module rwpg_ctrl import rwpg_pkg::*; #(
	parameter int LEDS = LEDS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         frame_tick,
	input  wire rwpg_status_t status,
	output rwpg_cmd_t         cmd
);

	localparam int               CNT_W    = $clog2(SETUP_CYCLES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEDS - 1);

	rwpg_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.start = (state_q == ST_SETUP);
	assign cmd.issue = (state_q == ST_RUN) && status.adv;
	assign cmd.last  = (idx_q == LAST_IDX);
	assign cmd.idx   = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// a zero tick is taken and dropped
					if (in_valid && frame_tick) begin
						state_q <= ST_SETUP;
						cnt_q   <= '0;
						idx_q   <= '0;
					end
				end
				ST_SETUP: begin
					if (cnt_q == CNT_W'(SETUP_CYCLES - 1)) begin
						state_q <= ST_RUN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (status.adv) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RWPG_ASSERT_NOW(a_issue_in_run, clk, arst_n, cmd.issue, (state_q == ST_RUN) && status.adv)
	`RWPG_ASSERT_NEXT(a_last_ends_frame, clk, arst_n, cmd.issue && cmd.last, state_q == ST_IDLE)
	`RWPG_ASSERT_NEXT(a_tick_starts_setup, clk, arst_n, in_valid && in_ready && frame_tick, state_q == ST_SETUP)

endmodule

`default_nettype wire

// ===== rtl/rwpg_datapath.sv =====
// Config registers, derived levels, hue walk and HSV pixel pipeline.
// Depends on rwpg_pkg; driven by rwpg_ctrl through the command struct.
`default_nettype none

module rwpg_datapath import rwpg_pkg::*; #(
	parameter int LEDS = LEDS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire rwpg_cmd_t             cmd,
	output rwpg_status_t               status,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [IDX_W-1:0]           led_index,
	output logic [CH_W-1:0]            red,
	output logic [CH_W-1:0]            green,
	output logic [CH_W-1:0]            blue,
	output logic                       last_pixel
);

	localparam int STEP_Q = 360 / LEDS;
	localparam int STEP_R = 360 % LEDS;
	// 5243 / 2^19 and 17477 / 2^20: exact floors of /100 and /60 over the operand ranges used
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [14:0] RECIP_60  = 15'd17477;

	logic [PCT_W-1:0] sat_q, bright_q;
	logic [HUE_W-1:0] step_q, base_q;

	// derived levels
	logic [14:0]     prod_b_q, prod_l_q;
	logic [27:0]     peak_full, low_full;
	logic [CH_W-1:0] peak_q, low_q, span_q;
	logic [PCT_W-1:0] inv_sat;

	// hue walk
	logic [HUE_W-1:0] off_q;
	logic [6:0]       rem_q, rem_sum;
	logic             rem_wrap;
	logic [HUE_W:0]   base_next, hue_sum;

	// pixel pipeline
	logic             adv;
	logic             v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, led_index_q;
	logic             last_s1, last_s2, last_s3, last_s4, last_pixel_q;
	logic [HUE_W-1:0] hue_s1;
	logic [2:0]       sec_c, sec_s2, sec_s3, sec_s4;
	logic [5:0]       mod_c, mod_s2;
	logic [13:0]      prod_s3;
	logic [28:0]      adj_full;
	logic [CH_W-1:0]  adj_s4, red_q, green_q, blue_q;
	logic [CH_W-1:0]  r_c, g_c, b_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q    <= PCT_W'(100);
			bright_q <= PCT_W'(20);
			step_q   <= HUE_W'(2);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SATURATION: sat_q    <= cfg_data[PCT_W-1:0];
				REG_BRIGHTNESS: bright_q <= cfg_data[PCT_W-1:0];
				REG_HUE_STEP:   step_q   <= cfg_data[HUE_W-1:0];
				default: ;
			endcase
		end
	end

	// peak and floor levels follow the config registers continuously
	assign inv_sat   = (sat_q > PCT_W'(100)) ? '0 : PCT_W'(7'd100 - sat_q);
	assign peak_full = 28'(prod_b_q) * 28'(RECIP_100);
	assign low_full  = 28'(prod_l_q) * 28'(RECIP_100);

	always_ff @(posedge clk) begin
		prod_b_q <= {bright_q, 8'h00} - 15'(bright_q);
		peak_q   <= (peak_full[27:19] > 9'd255) ? 8'hFF : peak_full[26:19];
		prod_l_q <= 15'(peak_q) * 15'(inv_sat);
		low_q    <= low_full[26:19];
		span_q   <= peak_q - low_q;
	end

	assign rem_sum   = rem_q + 7'(STEP_R);
	assign rem_wrap  = (rem_sum >= 7'(LEDS));
	assign base_next = {1'b0, base_q} + {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			off_q  <= '0;
			rem_q  <= '0;
		end else begin
			if (cmd.start) begin
				off_q <= '0;
				rem_q <= '0;
			end else if (cmd.issue) begin
				off_q <= off_q + HUE_W'(STEP_Q) + HUE_W'(rem_wrap);
				rem_q <= rem_wrap ? (rem_sum - 7'(LEDS)) : rem_sum;
			end
			// the sum is not wrapped: reaching a full turn restarts at zero
			if (cmd.issue && cmd.last) begin
				base_q <= (base_next >= 10'd360) ? '0 : base_next[HUE_W-1:0];
			end
		end
	end

	assign adv        = !out_valid_q || out_ready;
	assign status.adv = adv;
	assign hue_sum    = {1'b0, base_q} + {1'b0, off_q};

	always_comb begin
		if (hue_s1 >= 9'd300) begin
			sec_c = 3'd5;
			mod_c = 6'(hue_s1 - 9'd300);
		end else if (hue_s1 >= 9'd240) begin
			sec_c = 3'd4;
			mod_c = 6'(hue_s1 - 9'd240);
		end else if (hue_s1 >= 9'd180) begin
			sec_c = 3'd3;
			mod_c = 6'(hue_s1 - 9'd180);
		end else if (hue_s1 >= 9'd120) begin
			sec_c = 3'd2;
			mod_c = 6'(hue_s1 - 9'd120);
		end else if (hue_s1 >= 9'd60) begin
			sec_c = 3'd1;
			mod_c = 6'(hue_s1 - 9'd60);
		end else begin
			sec_c = 3'd0;
			mod_c = 6'(hue_s1);
		end
	end

	assign adj_full = 29'(prod_s3) * 29'(RECIP_60);

	always_comb begin
		case (sec_s4)
			3'd0: begin
				r_c = peak_q;          g_c = low_q + adj_s4;  b_c = low_q;
			end
			3'd1: begin
				r_c = peak_q - adj_s4; g_c = peak_q;          b_c = low_q;
			end
			3'd2: begin
				r_c = low_q;           g_c = peak_q;          b_c = low_q + adj_s4;
			end
			3'd3: begin
				r_c = low_q;           g_c = peak_q - adj_s4; b_c = peak_q;
			end
			3'd4: begin
				r_c = low_q + adj_s4;  g_c = low_q;           b_c = peak_q;
			end
			default: begin
				r_c = peak_q;          g_c = low_q;           b_c = peak_q - adj_s4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1       <= cmd.idx;
			last_s1      <= cmd.last;
			hue_s1       <= (hue_sum >= 10'd360) ? HUE_W'(hue_sum - 10'd360) : hue_sum[HUE_W-1:0];
			idx_s2       <= idx_s1;
			last_s2      <= last_s1;
			sec_s2       <= sec_c;
			mod_s2       <= mod_c;
			idx_s3       <= idx_s2;
			last_s3      <= last_s2;
			sec_s3       <= sec_s2;
			prod_s3      <= 14'(span_q) * 14'(mod_s2);
			idx_s4       <= idx_s3;
			last_s4      <= last_s3;
			sec_s4       <= sec_s3;
			adj_s4       <= adj_full[27:20];
			led_index_q  <= idx_s4;
			last_pixel_q <= last_s4;
			red_q        <= r_c;
			green_q      <= g_c;
			blue_q       <= b_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_index  = led_index_q;
	assign last_pixel = last_pixel_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;

endmodule

`default_nettype wire
